### rtl/lpli_pkg.sv
// Package: shared constants and types for the layered profile lookup.
`timescale 1ns / 1ps
package lpli_pkg;
	localparam int MAX_LAYERS_DEF = 64;
	localparam int THICK_W = 24;
	localparam int VAL_W   = 16;
	localparam int DEPTH_W = 31;
	localparam int SHIFT_W = 25;
	localparam int CUM_W   = 32;
	localparam int NL_W    = 7;
	localparam int IDX_W   = 6;
	localparam int CFG_W   = 7;
	localparam int OFF_W   = 32;
	localparam int QUO_W   = 17;

	localparam logic [0:0] REG_NUM_LAYERS  = 1'd0;
	localparam logic [0:0] REG_INTERP_MODE = 1'd1;
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_OUT
	} lpli_state_t;

	// One layer entry: the thickness and the vp, vs and rho values held by a cell.
	typedef struct packed {
		logic [THICK_W-1:0] thick;
		logic [VAL_W-1:0]   vp;
		logic [VAL_W-1:0]   vs;
		logic [VAL_W-1:0]   rho;
	} lpli_layer_t;

	// Walk token passed down the chain during a query.
	typedef struct packed {
		logic             active;
		logic             found;
		logic [CUM_W-1:0] cum;
	} lpli_walk_t;
endpackage

### rtl/lpli_if.sv
// Interfaces: input and output valid/ready channels.
`timescale 1ns / 1ps
interface lpli_in_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 kind;
	logic [lpli_pkg::IDX_W-1:0]           layer_index;
	logic [lpli_pkg::THICK_W-1:0]         layer_thickness_in;
	logic [lpli_pkg::VAL_W-1:0]           vp_in;
	logic [lpli_pkg::VAL_W-1:0]           vs_in;
	logic [lpli_pkg::VAL_W-1:0]           rho_in;
	logic signed [lpli_pkg::DEPTH_W-1:0]  depth;
	logic signed [lpli_pkg::SHIFT_W-1:0]  depth_shift;
	modport source (output valid, kind, layer_index, layer_thickness_in, vp_in, vs_in,
		rho_in, depth, depth_shift, input ready);
	modport sink (input valid, kind, layer_index, layer_thickness_in, vp_in, vs_in,
		rho_in, depth, depth_shift, output ready);
endinterface

interface lpli_out_if;
	logic                       valid;
	logic                       ready;
	logic [lpli_pkg::VAL_W-1:0] vp_out;
	logic [lpli_pkg::VAL_W-1:0] vs_out;
	logic [lpli_pkg::VAL_W-1:0] rho_out;
	logic                       status;
	modport source (output valid, vp_out, vs_out, rho_out, status, input ready);
	modport sink (input valid, vp_out, vs_out, rho_out, status, output ready);
endinterface

### rtl/lpli_cell.sv
// Cell: one layer entry plus one step of the cumulative-thickness walk.
`timescale 1ns / 1ps
module lpli_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load_en,
	input  lpli_pkg::lpli_layer_t     load_data,
	input  logic                      last,
	input  logic [lpli_pkg::CUM_W-1:0] d,
	input  lpli_pkg::lpli_walk_t      walk_in,
	output lpli_pkg::lpli_walk_t      walk_out,
	output logic                      hit,
	output lpli_pkg::lpli_layer_t     entry
);
	lpli_pkg::lpli_layer_t entry_q;
	lpli_pkg::lpli_walk_t  walk_q;
	logic [lpli_pkg::CUM_W:0] sum;

	assign sum = {1'b0, walk_in.cum} + {{(lpli_pkg::CUM_W+1-lpli_pkg::THICK_W){1'b0}},
		entry_q.thick};
	// Chosen when this is the first cell whose end lies past d, or the last layer.
	assign hit = walk_in.active && !walk_in.found && (sum > {1'b0, d} || last);

	always_ff @(posedge clk) begin
		if (load_en)
			entry_q <= load_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
		end else begin
			walk_q.active <= walk_in.active;
			walk_q.found  <= walk_in.found | hit;
			walk_q.cum    <= (walk_in.found | hit) ? walk_in.cum : sum[lpli_pkg::CUM_W-1:0];
		end
	end

	assign walk_out = walk_q;
	assign entry    = entry_q;
endmodule

### rtl/lpli_div.sv
// Divider: restoring division of a signed product by a layer thickness.
`timescale 1ns / 1ps
module lpli_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         neg,
	input  logic [47:0]                  dividend,
	input  logic [lpli_pkg::THICK_W-1:0] divisor,
	output logic                         done,
	output logic [lpli_pkg::QUO_W:0]     quotient
);
	logic [47:0]                  num_q;
	logic [lpli_pkg::THICK_W:0]   rem_q;
	logic [5:0]                   cnt_q;
	logic                         busy_q;
	logic                         neg_q;
	logic [lpli_pkg::THICK_W+1:0] trial;
	logic [lpli_pkg::THICK_W:0]   shifted;

	assign shifted = {rem_q[lpli_pkg::THICK_W-1:0], num_q[47]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			neg_q <= neg;
		end else if (busy_q) begin
			if (!trial[lpli_pkg::THICK_W+1]) begin
				rem_q <= trial[lpli_pkg::THICK_W:0];
				num_q <= {num_q[46:0], 1'b1};
			end else begin
				rem_q <= shifted;
				num_q <= {num_q[46:0], 1'b0};
			end
		end
	end

	// Magnitude is below 2^16, so the low bits carry the whole quotient.
	assign quotient = neg_q ? -num_q[lpli_pkg::QUO_W:0] : num_q[lpli_pkg::QUO_W:0];
endmodule

### rtl/layered_profile_lookup_interp.sv
// Top level: layered profile lookup with optional linear interpolation.
`timescale 1ns / 1ps
//  channel  | dir | handshake    | payload
//  in_ch    | in  | valid/ready  | kind, layer_index, thickness, vp/vs/rho, depth, shift
//  out_ch   | out | valid/ready  | vp_out, vs_out, rho_out, status
//  cfg      | in  | cfg_we       | cfg_index (1 bit), cfg_data (7 bits)
// A load transaction is written into its cell at the accepting edge; ready stays high,
// so loads may follow back to back.
// A query walks the cell chain one cell per cycle in ST_WALK, then passes ST_OUT,
// which sets the result valid in step mode.
// Linear mode adds ST_DIV, running the vp, vs and rho lanes through the divider in turn.
// A negative shifted depth sets its result valid in the cycle after acceptance.
// The result register holds until out_ch takes it; ready returns the cycle after that.
// Reset clears control state and the config registers; layer entries stay undefined until loaded.
module layered_profile_lookup_interp #(
	parameter int MAX_LAYERS = lpli_pkg::MAX_LAYERS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lpli_in_if.sink                    in_ch,
	lpli_out_if.source                 out_ch,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [lpli_pkg::CFG_W-1:0] cfg_data
);
	localparam int LI_W     = $clog2(MAX_LAYERS);
	localparam int CW       = $clog2(MAX_LAYERS + 1);
	localparam int DEPTH_W1 = lpli_pkg::DEPTH_W + 1;

	logic [lpli_pkg::NL_W-1:0] num_layers_q;
	logic                      interp_mode_q;
	lpli_pkg::lpli_state_t     state_q, state_d;

	logic [lpli_pkg::CUM_W-1:0] d_q;
	logic [CW-1:0]              step_q;
	logic [LI_W-1:0]            nlast;

	lpli_pkg::lpli_walk_t  walk [MAX_LAYERS+1];
	lpli_pkg::lpli_layer_t entry [MAX_LAYERS];
	logic [MAX_LAYERS-1:0] hit;
	lpli_pkg::lpli_layer_t load_data;

	logic [LI_W-1:0]             sel_q;
	logic [lpli_pkg::CUM_W-1:0]  cum_sel_q;
	logic                        found_any_q;
	lpli_pkg::lpli_layer_t       cur_q, prev_q;
	logic [lpli_pkg::VAL_W-1:0]  res_vp_q, res_vs_q, res_rho_q;
	logic                        res_st_q;
	logic                        out_valid_q;
	logic [1:0]                  lane_q;

	logic signed [lpli_pkg::DEPTH_W:0] sum;
	logic query_go, load_go;

	// Clamp layer count to 1..MAX_LAYERS; index of the last layer in use.
	always_comb begin
		if (num_layers_q == '0)
			nlast = '0;
		else if (32'(num_layers_q) > MAX_LAYERS)
			nlast = LI_W'(MAX_LAYERS - 1);
		else
			nlast = LI_W'(num_layers_q - 7'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_layers_q  <= 7'd1;
			interp_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lpli_pkg::REG_NUM_LAYERS:  num_layers_q  <= cfg_data;
				lpli_pkg::REG_INTERP_MODE: interp_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign sum = DEPTH_W1'(in_ch.depth) + DEPTH_W1'(in_ch.depth_shift);

	assign in_ch.ready = (state_q == lpli_pkg::ST_IDLE) && !out_valid_q;
	assign load_go  = in_ch.valid && in_ch.ready && (in_ch.kind == lpli_pkg::KIND_LOAD);
	assign query_go = in_ch.valid && in_ch.ready && (in_ch.kind == lpli_pkg::KIND_QUERY);

	assign load_data = '{thick: in_ch.layer_thickness_in, vp: in_ch.vp_in,
		vs: in_ch.vs_in, rho: in_ch.rho_in};

	// Walk token enters at cell 0 on the cycle after a non-negative query.
	assign walk[0] = '{active: (state_q == lpli_pkg::ST_WALK) && (step_q == '0),
		found: 1'b0, cum: '0};

	for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_cell
		lpli_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.load_en  (load_go && (32'(in_ch.layer_index) == g)),
			.load_data(load_data),
			.last     (LI_W'(g) == nlast),
			.d        (d_q),
			.walk_in  (walk[g]),
			.walk_out (walk[g+1]),
			.hit      (hit[g]),
			.entry    (entry[g])
		);
	end

	// Capture the chosen layer while the token passes; prev is its upper neighbor.
	always_ff @(posedge clk) begin
		for (int k = 0; k < MAX_LAYERS; k++) begin
			if (hit[k]) begin
				sel_q     <= LI_W'(k);
				cum_sel_q <= walk[k].cum;
				cur_q     <= entry[k];
				prev_q    <= (k == 0) ? entry[0] : entry[(k == 0) ? 0 : k-1];
			end
		end
	end

	// Linear interpolation lanes: vp, vs, rho through one shared divider.
	logic signed [lpli_pkg::VAL_W:0]  range;
	logic [lpli_pkg::VAL_W-1:0]       pv, cv;
	logic [lpli_pkg::OFF_W-1:0]       off;
	logic [47:0]                      prod_s1;
	logic                             neg_s1;
	logic [lpli_pkg::VAL_W-1:0]       mag;
	logic                             div_start, div_done;
	logic [lpli_pkg::QUO_W:0]         quo;
	logic [1:0]                       mstep_q;
	logic [lpli_pkg::VAL_W-1:0]       interp_val;

	always_comb begin
		case (lane_q)
			2'd0:    begin pv = prev_q.vp;  cv = cur_q.vp;  end
			2'd1:    begin pv = prev_q.vs;  cv = cur_q.vs;  end
			default: begin pv = prev_q.rho; cv = cur_q.rho; end
		endcase
	end
	assign range = $signed({1'b0, cv}) - $signed({1'b0, pv});
	assign mag   = range[lpli_pkg::VAL_W] ? lpli_pkg::VAL_W'(-range) : range[lpli_pkg::VAL_W-1:0];
	assign off   = d_q - cum_sel_q;

	always_ff @(posedge clk) begin
		prod_s1 <= 48'(mag) * 48'(off);
		neg_s1  <= range[lpli_pkg::VAL_W];
	end

	assign div_start = (state_q == lpli_pkg::ST_DIV) && (mstep_q == 2'd2);
	assign interp_val = pv + quo[lpli_pkg::VAL_W-1:0];

	lpli_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.neg     (neg_s1),
		.dividend(prod_s1),
		.divisor (cur_q.thick),
		.done    (div_done),
		.quotient(quo)
	);

	logic walk_done;
	logic use_interp;
	assign walk_done  = (state_q == lpli_pkg::ST_WALK) && (32'(step_q) == MAX_LAYERS + 1);
	assign use_interp = interp_mode_q && (sel_q != '0) && (sel_q != nlast);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpli_pkg::ST_IDLE: if (query_go && !sum[lpli_pkg::DEPTH_W]) state_d = lpli_pkg::ST_WALK;
			lpli_pkg::ST_WALK: if (walk_done) state_d = use_interp ? lpli_pkg::ST_DIV
				: lpli_pkg::ST_OUT;
			lpli_pkg::ST_DIV:  if (div_done && lane_q == 2'd2) state_d = lpli_pkg::ST_OUT;
			lpli_pkg::ST_OUT:  state_d = lpli_pkg::ST_IDLE;
			default:           state_d = lpli_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpli_pkg::ST_IDLE;
			step_q      <= '0;
			lane_q      <= '0;
			mstep_q     <= '0;
			out_valid_q <= 1'b0;
			found_any_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			found_any_q <= 1'b0;
			if (state_q == lpli_pkg::ST_WALK)
				step_q <= step_q + CW'(1);
			else
				step_q <= '0;
			if (state_q == lpli_pkg::ST_DIV) begin
				if (mstep_q != 2'd3)
					mstep_q <= mstep_q + 2'd1;
				if (div_done) begin
					lane_q  <= lane_q + 2'd1;
					mstep_q <= '0;
				end
			end else begin
				lane_q  <= '0;
				mstep_q <= '0;
			end
			if (out_ch.valid && out_ch.ready)
				out_valid_q <= 1'b0;
			else if ((query_go && sum[lpli_pkg::DEPTH_W]) || state_q == lpli_pkg::ST_OUT)
				out_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (query_go)
			d_q <= lpli_pkg::CUM_W'(sum);
		if (query_go && sum[lpli_pkg::DEPTH_W]) begin
			res_vp_q <= '0; res_vs_q <= '0; res_rho_q <= '0; res_st_q <= 1'b1;
		end else if (walk_done && !use_interp) begin
			res_vp_q <= cur_q.vp; res_vs_q <= cur_q.vs; res_rho_q <= cur_q.rho;
			res_st_q <= 1'b0;
		end else if (state_q == lpli_pkg::ST_DIV && div_done) begin
			res_st_q <= 1'b0;
			case (lane_q)
				2'd0:    res_vp_q  <= interp_val;
				2'd1:    res_vs_q  <= interp_val;
				default: res_rho_q <= interp_val;
			endcase
		end
	end

	assign out_ch.valid   = out_valid_q && !found_any_q;
	assign out_ch.vp_out  = res_vp_q;
	assign out_ch.vs_out  = res_vs_q;
	assign out_ch.rho_out = res_rho_q;
	assign out_ch.status  = res_st_q;
endmodule

### test/layered_profile_lookup_interp_tb.sv
// Testbench for the layered profile lookup: self-checking, random stimulus with handshake stalls.
`timescale 1ns / 1ps
module layered_profile_lookup_interp_tb;
	localparam int NLAYERS   = lpli_pkg::MAX_LAYERS_DEF;
	localparam int IDX_W     = lpli_pkg::IDX_W;
	localparam int THICK_W   = lpli_pkg::THICK_W;
	localparam int VAL_W     = lpli_pkg::VAL_W;
	localparam int DEPTH_W   = lpli_pkg::DEPTH_W;
	localparam int SHIFT_W   = lpli_pkg::SHIFT_W;
	localparam int CFG_W     = lpli_pkg::CFG_W;
	localparam int WDOG_MAX  = 6000;   // limit above a linear query plus the long hold
	localparam int HOLD_LEN  = 700;    // long receiver hold-off, in cycles
	localparam int MAX_SHOWN = 10;

	typedef struct {
		logic                      kind;
		logic [IDX_W-1:0]          layer_index;
		logic [THICK_W-1:0]        thick;
		logic [VAL_W-1:0]          vp;
		logic [VAL_W-1:0]          vs;
		logic [VAL_W-1:0]          rho;
		logic signed [DEPTH_W-1:0] depth;
		logic signed [SHIFT_W-1:0] shift;
	} lpli_item_t;

	typedef struct {
		logic [VAL_W-1:0] vp;
		logic [VAL_W-1:0] vs;
		logic [VAL_W-1:0] rho;
		logic             status;
	} lpli_sample_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	lpli_in_if  in_ch();
	lpli_out_if out_ch();

	layered_profile_lookup_interp u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Profile mirror used for prediction, updated in transaction order.
	logic [THICK_W-1:0] prof_thick [NLAYERS];
	logic [VAL_W-1:0]   prof_vp    [NLAYERS];
	logic [VAL_W-1:0]   prof_vs    [NLAYERS];
	logic [VAL_W-1:0]   prof_rho   [NLAYERS];
	int unsigned        cur_layers;
	bit                 cur_linear;

	// Planning copy of thicknesses, used only to aim queries at layers.
	logic [THICK_W-1:0] plan_thick [NLAYERS];
	int unsigned        plan_layers;

	lpli_item_t   pending_items[$];
	lpli_sample_t expected_samples[$];

	int  mismatches   = 0;
	int  samples_seen = 0;
	int  queries_sent = 0;
	int  loads_sent   = 0;
	int  gaps_seen    = 0;
	int  wdog_cnt     = 0;
	bit  calm         = 1'b0;   // no random idling on either side while set
	bit  hold_req     = 1'b0;
	logic holding;
	int  hold_cnt;
	lpli_item_t drv_item;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Interpolate between two layer values; quotient truncates toward zero.
	function automatic logic [VAL_W-1:0] blend(logic [VAL_W-1:0] prev, logic [VAL_W-1:0] cur,
			longint offs, longint thick);
		longint span;
		longint q;
		if (thick == 0)
			return cur;
		span = longint'(cur) - longint'(prev);
		q = (span * offs) / thick;
		return VAL_W'(longint'(prev) + q);
	endfunction

	// Apply one accepted transaction to the profile mirror; return 1 if a result is due.
	function automatic bit profile_apply(lpli_item_t it, output lpli_sample_t res);
		longint sum;
		longint cum;
		int unsigned n;
		int unsigned i;
		res = '{default: '0};
		if (it.kind == lpli_pkg::KIND_LOAD) begin
			if (int'(it.layer_index) < NLAYERS) begin
				prof_thick[it.layer_index] = it.thick;
				prof_vp[it.layer_index]    = it.vp;
				prof_vs[it.layer_index]    = it.vs;
				prof_rho[it.layer_index]   = it.rho;
			end
			return 1'b0;
		end
		sum = longint'(it.depth) + longint'(it.shift);
		if (sum < 0) begin
			res.status = 1'b1;
			return 1'b1;
		end
		n = cur_layers;
		if (n == 0)
			n = 1;
		if (n > NLAYERS)
			n = NLAYERS;
		cum = 0;
		for (i = 0; i < n; i++) begin
			if (cum + longint'(prof_thick[i]) > sum)
				break;
			cum += longint'(prof_thick[i]);
		end
		if (i >= n - 1) begin
			res.vp  = prof_vp[n-1];
			res.vs  = prof_vs[n-1];
			res.rho = prof_rho[n-1];
		end else if (!cur_linear || i == 0) begin
			res.vp  = prof_vp[i];
			res.vs  = prof_vs[i];
			res.rho = prof_rho[i];
		end else begin
			res.vp  = blend(prof_vp[i-1],  prof_vp[i],  sum - cum, longint'(prof_thick[i]));
			res.vs  = blend(prof_vs[i-1],  prof_vs[i],  sum - cum, longint'(prof_thick[i]));
			res.rho = blend(prof_rho[i-1], prof_rho[i], sum - cum, longint'(prof_thick[i]));
		end
		return 1'b1;
	endfunction

	function automatic logic [VAL_W-1:0] rand_val();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return VAL_W'($urandom);
		endcase
	endfunction

	function automatic logic [THICK_W-1:0] rand_thick();
		case ($urandom_range(19))
			0: return THICK_W'(1);
			1: return '1;
			2, 3: return THICK_W'($urandom_range(16777215, 1));
			default: return THICK_W'($urandom_range(4000, 1));
		endcase
	endfunction

	task automatic push_load(int idx, logic [THICK_W-1:0] th, logic [VAL_W-1:0] vp,
			logic [VAL_W-1:0] vs, logic [VAL_W-1:0] rho);
		lpli_item_t it;
		it = '{default: '0};
		it.kind        = lpli_pkg::KIND_LOAD;
		it.layer_index = IDX_W'(idx);
		it.thick       = th;
		it.vp          = vp;
		it.vs          = vs;
		it.rho         = rho;
		it.depth       = DEPTH_W'($urandom);
		it.shift       = SHIFT_W'($urandom);
		plan_thick[idx] = th;
		pending_items.push_back(it);
	endtask

	task automatic push_query(longint dep, longint sh);
		lpli_item_t it;
		it = '{default: '0};
		it.kind        = lpli_pkg::KIND_QUERY;
		it.layer_index = IDX_W'($urandom);
		it.thick       = THICK_W'($urandom);
		it.vp          = VAL_W'($urandom);
		it.vs          = VAL_W'($urandom);
		it.rho         = VAL_W'($urandom);
		it.depth       = DEPTH_W'(dep);
		it.shift       = SHIFT_W'(sh);
		pending_items.push_back(it);
	endtask

	// Aim a query at a random point inside a layer or below the bottom; some go negative or take any values.
	task automatic push_aimed_query();
		longint cum;
		longint target;
		longint sh;
		int lay;
		int i;
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			// Mostly a negative shifted depth: data gap.
			push_query(-longint'($urandom_range(1000000)) - 1,
				longint'($urandom_range(200)) - 100);
			return;
		end
		if (pick < 14) begin
			// Anything the fields allow.
			push_query(longint'($urandom), longint'($urandom));
			return;
		end
		lay = $urandom_range(plan_layers);   // plan_layers means below the bottom
		cum = 0;
		for (i = 0; i < lay && i < NLAYERS; i++)
			cum += longint'(plan_thick[i]);
		if (lay < plan_layers)
			target = cum + longint'($urandom_range(int'(plan_thick[lay]) - 1));
		else
			target = cum + longint'($urandom_range(5000));
		if (target > 1073741823 - 16777216)
			target = 1073741823 - 16777216;
		sh = longint'($urandom_range(33554431)) - 16777216;
		if ($urandom_range(3) == 0)
			sh = 0;
		push_query(target - sh, sh);
	endtask

	// Wait until every transaction is accepted and every result is checked.
	task automatic wait_idle();
		do @(negedge clk);
		while (pending_items.size() != 0 || in_ch.valid || expected_samples.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(value);
		if (idx == lpli_pkg::REG_NUM_LAYERS)
			cur_layers = value & 32'h7F;
		else
			cur_linear = value[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(int layers, bit linear, int items, int load_pct);
		int k;
		write_reg(lpli_pkg::REG_NUM_LAYERS, layers);
		write_reg(lpli_pkg::REG_INTERP_MODE, int'(linear));
		if (layers < 1)
			plan_layers = 1;
		else if (layers > NLAYERS)
			plan_layers = NLAYERS;
		else
			plan_layers = layers;
		for (k = 0; k < items; k++) begin
			if ($urandom_range(99) < load_pct)
				push_load($urandom_range(NLAYERS - 1), rand_thick(), rand_val(), rand_val(),
					rand_val());
			else
				push_aimed_query();
		end
	endtask

	// Stimulus and configuration sequence.
	initial begin
		int k;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		cur_layers  = 1;
		cur_linear  = 1'b0;
		plan_layers = 1;
		for (k = 0; k < NLAYERS; k++) begin
			prof_thick[k] = '0;
			prof_vp[k]    = '0;
			prof_vs[k]    = '0;
			prof_rho[k]   = '0;
			plan_thick[k] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill every layer entry before any query reads it.
		for (k = 0; k < NLAYERS; k++)
			push_load(k, rand_thick(), rand_val(), rand_val(), rand_val());
		wait_idle();

		run_phase(64, 1'b0, 350, 10);
		wait_idle();

		// Long stretch with no idling on either side.
		calm = 1'b1;
		run_phase(64, 1'b1, 450, 10);
		wait_idle();
		calm = 1'b0;

		// Receiver holds off while the sender keeps offering.
		run_phase(7, 1'b1, 300, 15);
		@(negedge clk);
		hold_req = 1'b1;
		wait (holding);
		@(negedge clk);
		hold_req = 1'b0;
		wait_idle();

		run_phase(0, 1'b0, 100, 10);
		wait_idle();
		run_phase(100, 1'b1, 250, 10);
		wait_idle();
		run_phase(1, 1'b1, 100, 10);
		wait_idle();
		run_phase(33, 1'b1, 336, 12);
		wait_idle();

		$display("Covered %0d loads and %0d queries, %0d results checked, %0d data gaps.",
			loads_sent, queries_sent, samples_seen, gaps_seen);
		$display("Step and linear modes, clamped layer counts, idling and a %0d-cycle hold.",
			HOLD_LEN);
		if (mismatches == 0 && expected_samples.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Clock-edge driver: hold the current transaction until accepted, then advance.
	always @(posedge clk) begin
		lpli_sample_t res;
		if (!arst_n) begin
			in_ch.valid              <= 1'b0;
			in_ch.kind               <= 1'b0;
			in_ch.layer_index        <= '0;
			in_ch.layer_thickness_in <= '0;
			in_ch.vp_in              <= '0;
			in_ch.vs_in              <= '0;
			in_ch.rho_in             <= '0;
			in_ch.depth              <= '0;
			in_ch.depth_shift        <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (profile_apply(drv_item, res))
					expected_samples.push_back(res);
				if (drv_item.kind == lpli_pkg::KIND_LOAD)
					loads_sent++;
				else
					queries_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_items.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
					drv_item = pending_items.pop_front();
					in_ch.valid              <= 1'b1;
					in_ch.kind               <= drv_item.kind;
					in_ch.layer_index        <= drv_item.layer_index;
					in_ch.layer_thickness_in <= drv_item.thick;
					in_ch.vp_in              <= drv_item.vp;
					in_ch.vs_in              <= drv_item.vs;
					in_ch.rho_in             <= drv_item.rho;
					in_ch.depth              <= drv_item.depth;
					in_ch.depth_shift        <= drv_item.shift;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off, counted here.
	always @(posedge clk) begin
		if (!arst_n) begin
			holding  <= 1'b0;
			hold_cnt <= 0;
		end else if (holding) begin
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_LEN - 1)
				holding <= 1'b0;
		end else if (hold_req) begin
			holding  <= 1'b1;
			hold_cnt <= 0;
		end
	end

	// Monitor: check each result transaction against the prediction.
	always @(posedge clk) begin
		lpli_sample_t exp_s;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				samples_seen++;
				if (out_ch.status === 1'b1)
					gaps_seen++;
				if (expected_samples.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: unexpected result vp %0d vs %0d rho %0d status %0d",
							out_ch.vp_out, out_ch.vs_out, out_ch.rho_out, out_ch.status);
				end else begin
					exp_s = expected_samples.pop_front();
					if (out_ch.vp_out !== exp_s.vp || out_ch.vs_out !== exp_s.vs ||
							out_ch.rho_out !== exp_s.rho || out_ch.status !== exp_s.status) begin
						mismatches++;
						if (mismatches <= MAX_SHOWN)
							$display("mismatch: expected %0d %0d %0d st %0d, got %0d %0d %0d st %0d",
								exp_s.vp, exp_s.vs, exp_s.rho, exp_s.status, out_ch.vp_out,
								out_ch.vs_out, out_ch.rho_out, out_ch.status);
					end
				end
			end
			out_ch.ready <= !holding && (calm || $urandom_range(99) >= 20);
		end
	end

	// Watchdog: end the run if nothing is accepted for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
				wdog_cnt <= 0;
			else
				wdog_cnt <= wdog_cnt + 1;
			if (wdog_cnt >= WDOG_MAX) begin
				$display("No transaction for %0d cycles; %0d results outstanding.",
					WDOG_MAX, expected_samples.size());
				$display("FAILED: results differ");
				$finish;
			end
		end
	end
endmodule
